// ===== rtl/core/lphm_pkg.sv =====
// ----------------------------------------------------------------------------
// lphm_pkg
// shared types and codes for the linear probing hash map
// ----------------------------------------------------------------------------
package lphm_pkg;

    localparam int KEY_BITS = 31;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_UPDATED   = 3'd1;
    localparam logic [2:0] STAT_FOUND     = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_REMOVED   = 3'd4;
    localparam logic [2:0] STAT_FULL      = 3'd5;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_USED    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    typedef struct packed {
        logic [1:0]          op;
        logic [KEY_BITS-1:0] key;
        logic [31:0]         value;
    } lphm_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [31:0] found_value;
        logic [6:0]  entry_total;
    } lphm_out_t;

endpackage

// ===== rtl/core/lphm_ram.sv =====
// ----------------------------------------------------------------------------
// lphm_ram
// generic single-clock ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
module lphm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/linear_probe_hash_map.sv =====
// probing: with a power-of-two capacity a valid op reads p slots from its home
// slot, p = 1 to CAPACITY, one ram read per cycle; an unused op skips the scan
// flow: a new word is taken only after the last result has moved to the output
// register, which may wait on m_ready; other capacities first find the home slot
// as a reciprocal remainder. reset: synchronous, active low; a sweep then marks
// every slot empty with s_ready low
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// open addressing key/value table with linear probing and deleted marks
// ----------------------------------------------------------------------------
module linear_probe_hash_map #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lphm_pkg::lphm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lphm_pkg::lphm_out_t m_data
);

    import lphm_pkg::*;

    localparam int IW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int VW     = VALUE_BITS;
    localparam int EW     = 2 + KEY_BITS + VW;
    localparam bit POW2   = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam int MOD_SH = KEY_BITS + IW;

    localparam logic [63:0] RECIP_W = ((64'd1 << MOD_SH) + 64'(CAPACITY - 1))
                                      / 64'(CAPACITY);
    localparam logic [32:0] RECIP   = RECIP_W[32:0];

    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [IW-1:0]       clr_idx_reg, clr_idx_next;
    logic [1:0]          op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [VW-1:0]       val_reg, val_next;
    logic [1:0]          step_reg, step_next;
    logic [63:0]         prod_reg, prod_next;
    logic [KEY_BITS-1:0] qc_reg, qc_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       n_reg, n_next;
    logic                have_del_reg, have_del_next;
    logic [IW-1:0]       first_del_reg, first_del_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [2:0]          res_status_reg, res_status_next;
    logic [IW-1:0]       res_slot_reg, res_slot_next;
    logic [31:0]         res_fval_reg, res_fval_next;
    logic                m_valid_reg, m_valid_next;
    lphm_out_t           out_reg, out_next;

    logic                we;
    logic [IW-1:0]       waddr, raddr;
    logic [EW-1:0]       wdata, rdata;

    logic [1:0]          rd_mark;
    logic [KEY_BITS-1:0] rd_key;
    logic [VW-1:0]       rd_val;
    logic [VW+31:0]      val_in_ext;
    logic [VW+31:0]      rd_val_ext;
    logic [IW+5:0]       slot_ext;
    logic [CW+6:0]       count_ext;
    logic [63:0]         quot_w;
    logic [KEY_BITS-1:0] rem_full;
    logic [IW-1:0]       rem_new;
    logic [IW-1:0]       idx_inc;
    logic                is_empty, is_hit, is_del, is_last;
    logic                have_del_now;
    logic [IW-1:0]       first_del_now;

    lphm_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_slots (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_mark    = rdata[EW-1 -: 2];
    assign rd_key     = rdata[VW +: KEY_BITS];
    assign rd_val     = rdata[VW-1:0];
    assign val_in_ext = {{VW{1'b0}}, s_data.value};
    assign rd_val_ext = {32'd0, rd_val};
    assign slot_ext   = {6'd0, res_slot_reg};
    assign count_ext  = {7'd0, count_reg};

    // home slot by reciprocal multiply, multiply back and subtract
    assign quot_w   = prod_reg >> MOD_SH;
    assign rem_full = key_reg - qc_reg;
    assign rem_new  = rem_full[IW-1:0];
    assign idx_inc  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    assign is_empty      = rd_mark == MARK_EMPTY;
    assign is_hit        = (rd_mark == MARK_USED) && (rd_key == key_reg);
    assign is_del        = rd_mark == MARK_DELETED;
    assign is_last       = n_reg == LAST_IDX;
    assign have_del_now  = have_del_reg || is_del;
    assign first_del_now = have_del_reg ? first_del_reg : idx_reg;

    always_comb begin
        case (state_reg)
            ST_IDLE: raddr = s_data.key[IW-1:0];
            ST_MOD:  raddr = rem_new;
            default: raddr = idx_inc;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        step_next       = step_reg;
        prod_next       = prod_reg;
        qc_next         = qc_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        have_del_next   = have_del_reg;
        first_del_next  = first_del_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_fval_next   = res_fval_reg;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        we              = 1'b0;
        waddr           = idx_reg;
        wdata           = {MARK_USED, key_reg, val_reg};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = clr_idx_reg;
                wdata = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next        = s_data.op;
                    key_next       = s_data.key;
                    val_next       = val_in_ext[VW-1:0];
                    step_next      = '0;
                    n_next         = '0;
                    have_del_next  = 1'b0;
                    first_del_next = '0;
                    idx_next       = s_data.key[IW-1:0];
                    if (!(s_data.op inside {OP_INSERT, OP_LOOKUP, OP_REMOVE})) begin
                        res_status_next = STAT_NOT_FOUND;
                        res_slot_next   = '0;
                        res_fval_next   = '0;
                        state_next      = ST_DONE;
                    end else if (POW2) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd0) begin
                    prod_next = 64'(key_reg) * 64'(RECIP);
                end else if (step_reg == 2'd1) begin
                    qc_next = KEY_BITS'(64'(quot_w[KEY_BITS-1:0]) * 64'(CAPACITY));
                end else begin
                    idx_next   = rem_new;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                idx_next        = idx_inc;
                n_next          = n_reg + 1'b1;
                have_del_next   = have_del_now;
                first_del_next  = first_del_now;
                res_slot_next   = '0;
                res_fval_next   = '0;
                res_status_next = STAT_NOT_FOUND;
                case (op_reg)
                    OP_INSERT: begin
                        if (is_hit) begin
                            we              = 1'b1;
                            waddr           = idx_reg;
                            res_status_next = STAT_UPDATED;
                            res_slot_next   = idx_reg;
                            state_next      = ST_DONE;
                        end else if (is_empty || is_last) begin
                            state_next = ST_DONE;
                            if (is_empty || have_del_now) begin
                                we              = 1'b1;
                                waddr           = (is_empty && !have_del_reg) ? idx_reg
                                                                              : first_del_now;
                                res_status_next = STAT_INSERTED;
                                res_slot_next   = waddr;
                                count_next      = count_reg + 1'b1;
                            end else begin
                                res_status_next = STAT_FULL;
                            end
                        end
                    end
                    OP_LOOKUP: begin
                        if (is_hit) begin
                            res_status_next = STAT_FOUND;
                            res_slot_next   = idx_reg;
                            res_fval_next   = rd_val_ext[31:0];
                            state_next      = ST_DONE;
                        end else if (is_empty || is_last) begin
                            state_next = ST_DONE;
                        end
                    end
                    OP_REMOVE: begin
                        if (is_hit) begin
                            we              = 1'b1;
                            waddr           = idx_reg;
                            wdata           = {MARK_DELETED, rd_key, rd_val};
                            res_status_next = STAT_REMOVED;
                            res_slot_next   = idx_reg;
                            if (count_reg != '0) begin
                                count_next = count_reg - 1'b1;
                            end
                            state_next = ST_DONE;
                        end else if (is_empty || is_last) begin
                            state_next = ST_DONE;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.status      = res_status_reg;
                    out_next.slot        = slot_ext[5:0];
                    out_next.found_value = res_fval_reg;
                    out_next.entry_total = count_ext[6:0];
                    m_valid_next         = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            have_del_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
            have_del_reg <= have_del_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        step_reg       <= step_next;
        prod_reg       <= prod_next;
        qc_reg         <= qc_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        first_del_reg  <= first_del_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_fval_reg   <= res_fval_next;
        out_reg        <= out_next;
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/core/lphm_checker.sv =====
// ----------------------------------------------------------------------------
// lphm_checker
// port-level checks on the result word of the hash map
// ----------------------------------------------------------------------------
module lphm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input lphm_pkg::lphm_out_t m_data
);

    import lphm_pkg::*;

    // result word holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status <= STAT_FULL))
        else $error("status code out of range");

    a_miss_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_NOT_FOUND || m_data.status == STAT_FULL)
        |-> m_data.slot == '0)
        else $error("slot not zero on miss or full");

    a_value_only_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STAT_FOUND) |-> m_data.found_value == '0)
        else $error("found value not zero without a hit");

endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// linear probing hash map testbench
// drives insert, lookup and remove words into the table, keeps its own copy
// of the slots and marks to predict every answer, and compares each answer
// field by field; probes are forced into long clusters, wrap-around, deleted
// slot reuse and a full table, with random idling on both channels
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lphm_pkg::*;

    localparam int SLOTS        = 64;
    localparam int RANDOM_ITEMS = 1730;
    localparam int LIMIT        = 1000000;

    class table_scoreboard;
        logic [KEY_BITS-1:0] keys [SLOTS];
        logic [31:0]         vals [SLOTS];
        logic [1:0]          marks [SLOTS];
        int unsigned         live;
        int                  errors;
        lphm_out_t           pending_answers [$];

        function new();
            foreach (marks[i]) marks[i] = MARK_EMPTY;
            live = 0;
            errors = 0;
        endfunction

        function bit find_slot(logic [KEY_BITS-1:0] key, output int where);
            int  idx;
            bit  stop;
            bit  hit;
            idx = int'(key % SLOTS);
            stop = 0;
            hit = 0;
            where = 0;
            for (int n = 0; n < SLOTS && !stop; n++) begin
                if (marks[idx] == MARK_EMPTY) begin
                    stop = 1;
                end else if (marks[idx] == MARK_USED && keys[idx] == key) begin
                    hit = 1;
                    stop = 1;
                    where = idx;
                end else begin
                    idx = (idx + 1) % SLOTS;
                end
            end
            return hit;
        endfunction

        function lphm_out_t answer_for(lphm_in_t w);
            lphm_out_t a;
            int        idx;
            int        first_del;
            int        target;
            bit        have_del;
            bit        have_empty;
            bit        hit;
            bit        stop;
            a = '0;
            a.status = STAT_NOT_FOUND;
            have_del = 0;
            have_empty = 0;
            hit = 0;
            stop = 0;
            first_del = 0;
            case (w.op)
                OP_INSERT: begin
                    idx = int'(w.key % SLOTS);
                    for (int n = 0; n < SLOTS && !stop; n++) begin
                        if (marks[idx] == MARK_EMPTY) begin
                            have_empty = 1;
                            stop = 1;
                        end else if (marks[idx] == MARK_USED && keys[idx] == w.key) begin
                            hit = 1;
                            stop = 1;
                        end else begin
                            if (marks[idx] == MARK_DELETED && !have_del) begin
                                have_del = 1;
                                first_del = idx;
                            end
                            idx = (idx + 1) % SLOTS;
                        end
                    end
                    if (hit) begin
                        vals[idx] = w.value;
                        a.status = STAT_UPDATED;
                        a.slot = idx[5:0];
                    end else if (have_del || have_empty) begin
                        target = have_del ? first_del : idx;
                        keys[target] = w.key;
                        vals[target] = w.value;
                        marks[target] = MARK_USED;
                        live++;
                        a.status = STAT_INSERTED;
                        a.slot = target[5:0];
                    end else begin
                        a.status = STAT_FULL;
                    end
                end
                OP_LOOKUP: begin
                    if (find_slot(w.key, idx)) begin
                        a.status = STAT_FOUND;
                        a.slot = idx[5:0];
                        a.found_value = vals[idx];
                    end
                end
                OP_REMOVE: begin
                    if (find_slot(w.key, idx)) begin
                        marks[idx] = MARK_DELETED;
                        if (live > 0) live--;
                        a.status = STAT_REMOVED;
                        a.slot = idx[5:0];
                    end
                end
                default: ;
            endcase
            a.entry_total = live[6:0];
            return a;
        endfunction

        function void note_request(lphm_in_t w);
            pending_answers.push_back(answer_for(w));
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        endfunction

        function void check_response(lphm_out_t got);
            lphm_out_t want;
            if (pending_answers.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected word, expected none, actual %h", $time, got);
                return;
            end
            want = pending_answers.pop_front();
            if (got.status !== want.status)
                report("status", 32'(want.status), 32'(got.status));
            if (got.slot !== want.slot)
                report("slot", 32'(want.slot), 32'(got.slot));
            if (got.found_value !== want.found_value)
                report("found_value", want.found_value, got.found_value);
            if (got.entry_total !== want.entry_total)
                report("entry_total", 32'(want.entry_total), 32'(got.entry_total));
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    lphm_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    lphm_out_t m_data;

    table_scoreboard     board;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  cycle_count = 0;
    logic [KEY_BITS-1:0] known_keys [$];

    linear_probe_hash_map #(
        .CAPACITY   (SLOTS),
        .VALUE_BITS (32)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random back-pressure, check every accepted word
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) board.check_response(m_data);
            m_ready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // valid stays high across back-to-back words, dropped only for a gap
    task automatic send_word(logic [1:0] op, logic [KEY_BITS-1:0] key, logic [31:0] value);
        lphm_in_t w;
        w.op = op;
        w.key = key;
        w.value = value;
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        board.note_request(w);
        if (op == OP_INSERT) begin
            known_keys.push_back(key);
            if (known_keys.size() > 128) void'(known_keys.pop_front());
        end
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    // mostly clustered home slots so probes run long and collide
    function automatic logic [KEY_BITS-1:0] pick_key();
        logic [5:0]          home;
        logic [KEY_BITS-7:0] upper;
        if (known_keys.size() > 0 && $urandom_range(0, 99) < 40)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        home = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
        upper = ($urandom_range(0, 1) != 0) ? (KEY_BITS-6)'($urandom_range(0, 3))
                                            : (KEY_BITS-6)'($urandom);
        return {upper, home};
    endfunction

    initial begin
        int         insert_pct;
        int         r;
        logic [1:0] op;

        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        send_idle_pct = 29;
        recv_idle_pct = 56;
        insert_pct = 50;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, collisions, wrap-around, update, deleted reuse
        send_word(OP_INSERT, 31'h0, 32'h0);
        send_word(OP_INSERT, 31'h7FFFFFFF, 32'hFFFFFFFF);
        send_word(OP_INSERT, 31'd64, 32'h12345678);
        send_word(OP_INSERT, 31'd127, 32'hA5A5A5A5);
        send_word(OP_LOOKUP, 31'd127, 32'h0);
        send_word(OP_LOOKUP, 31'h7FFFFFFF, 32'h0);
        send_word(OP_LOOKUP, 31'd128, 32'h0);
        send_word(OP_INSERT, 31'h0, 32'h5A5A5A5A);
        send_word(OP_LOOKUP, 31'h0, 32'hFFFFFFFF);
        send_word(OP_REMOVE, 31'h0, 32'h0);
        send_word(OP_LOOKUP, 31'd64, 32'h0);
        send_word(OP_REMOVE, 31'h0, 32'h0);
        send_word(OP_INSERT, 31'd192, 32'h0F0F0F0F);
        send_word(OP_UNUSED, 31'h55555555, 32'hAAAAAAAA);
        send_word(OP_REMOVE, 31'd127, 32'h0);
        send_word(OP_LOOKUP, 31'd127, 32'h0);
        send_word(OP_INSERT, 31'd127, 32'hF0F0F0F0);
        send_word(OP_REMOVE, 31'h7FFFFFFF, 32'h0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case (i * 3 / RANDOM_ITEMS)
                0: begin send_idle_pct = 29; recv_idle_pct = 56; end
                1: begin send_idle_pct = 56; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            // insert bias drifts so the table fills up and drains again
            if (i % 100 == 0) insert_pct = $urandom_range(25, 85);
            r = $urandom_range(0, 99);
            if (r < insert_pct) op = OP_INSERT;
            else if (r < insert_pct + (100 - insert_pct) / 2) op = OP_LOOKUP;
            else if (r < 98) op = OP_REMOVE;
            else op = OP_UNUSED;
            send_word(op, pick_key(), $urandom);
        end
        s_valid <= 1'b0;

        while (board.pending_answers.size() != 0) @(posedge aclk);
        repeat (SLOTS + 16) @(posedge aclk);
        if (board.errors == 0 && board.pending_answers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
